[src/rlt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Resource lock table package
// Shared types, codes and constants of the resource lock table.
// ---------------------------------------------------------------------------
package rlt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int RID_W           = 64;
  localparam int TASK_W          = 63;
  localparam int CFG_W           = 9;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int IN_DATA_W       = 128;
  localparam int OUT_DATA_W      = 8;
  localparam logic [9:0] LIMIT_ZERO = 10'd256;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_LOCK     = 2'd1,
    KIND_UNLOCK   = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_CONTENDED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_DECIDE
  } bk_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [RID_W-1:0]   rid;
    logic [TASK_W-1:0]  task_id;
  } cmd_t;

  typedef struct packed {
    logic [RID_W-1:0]   rid;
    logic               held;
    logic [TASK_W-1:0]  owner;
  } entry_t;

endpackage
`default_nettype wire

[src/resource_lock_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Resource lock table core
// Append-only table of resource identifiers with lock ownership per task.
// ---------------------------------------------------------------------------
// Requests enter on the in_ stream: in_tuser carries the kind (register,
// lock, unlock), in_tdata the resource and task identifiers. Each request
// yields one status item on the out_ stream. The cfg_ channel sets the entry
// limit and is always ready; write it only while the block is idle.
// A two-item queue parts the request front end from the search engine.
// The engine scans the registered entry memory one entry at a time, through a
// read state and a compare state per entry, up to the match (all registered
// entries when no match). Requests of the no-op kind and requests on an empty
// table skip the scan and go straight to the decide state.
// Reset empties the table and sets the limit to 256; no clearing pass runs.
// When the receiver stalls, the status item holds in the output register,
// the engine waits and the front end keeps accepting until its queue fills.
// ---------------------------------------------------------------------------
module resource_lock_table_core #(
  parameter int TABLE_DEPTH = rlt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [63:0] resource_id, [126:64] task_id, [127] zero
  input  wire logic [rlt_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [rlt_pkg::KIND_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] status, [7:2] zero
  output logic [rlt_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rlt_pkg::CFG_W-1:0]      cfg_data
);
  import rlt_pkg::*;

  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic [CFG_W-1:0] max_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_res_r <= LIMIT_ZERO[CFG_W-1:0];
    end else if (cfg_valid) begin
      max_res_r <= cfg_data;
    end
  end

  rlt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rlt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .max_resources (max_res_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule
`default_nettype wire

[src/rlt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Resource lock table front end
// Accepts request items, decodes the kind and queues them for the back end.
// ---------------------------------------------------------------------------
module rlt_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [rlt_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [rlt_pkg::KIND_W-1:0]   in_tuser,
  output logic                              cmd_valid,
  output rlt_pkg::cmd_t                     cmd,
  input  wire logic                         cmd_pop
);
  import rlt_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.kind    = kind_t'(in_tuser);
    dec.rid     = in_tdata[RID_W-1:0];
    dec.task_id = in_tdata[RID_W+TASK_W-1:RID_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule
`default_nettype wire

[src/rlt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Resource lock table back end
// Scans the entry memory for each request, updates it and issues the status.
// ---------------------------------------------------------------------------
module rlt_back #(
  parameter int TABLE_DEPTH = rlt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire rlt_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  input  wire logic [rlt_pkg::CFG_W-1:0]     max_resources,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rlt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import rlt_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CNTW > 10) ? CNTW : 10;

  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  bk_state_t       state_r, state_nxt;
  cmd_t            cmd_r;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic            take_cmd, out_free, last_idx, hit;
  logic [9:0]      lim10;
  logic            full;
  status_t         dec_status;

  assign out_free = !out_valid_r || out_tready;
  assign take_cmd = (state_r == BK_IDLE) && cmd_valid;
  assign cmd_pop  = take_cmd;
  assign hit      = (rd_q.rid == cmd_r.rid);
  assign last_idx = ({{(CNTW-AW){1'b0}}, idx_r} + CNTW'(1)) == count_r;
  assign lim10    = (max_resources == '0) ? LIMIT_ZERO : {1'b0, max_resources};
  assign full     = ({{(CMPW-CNTW){1'b0}}, count_r} >= CMPW'(TABLE_DEPTH)) ||
                    ({{(CMPW-CNTW){1'b0}}, count_r} >= {{(CMPW-10){1'b0}}, lim10});
  assign rd_addr  = idx_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == KIND_NOP || count_r == '0) ? BK_DECIDE : BK_READ;
        end
      end
      BK_READ: state_nxt = BK_CMP;
      BK_CMP: begin
        state_nxt = (hit || last_idx) ? BK_DECIDE : BK_READ;
      end
      BK_DECIDE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    dec_status = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_q;
    count_nxt  = count_r;
    unique case (cmd_r.kind)
      KIND_REGISTER: begin
        if (found_r) begin
          wr_en        = 1'b1;
          wr_data.held = 1'b0;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = count_r[AW-1:0];
          wr_data.rid   = cmd_r.rid;
          wr_data.held  = 1'b0;
          wr_data.owner = '0;
          count_nxt     = count_r + CNTW'(1);
        end
      end
      KIND_LOCK: begin
        if (!found_r) begin
          dec_status = ST_UNKNOWN;
        end else if (rd_q.held && rd_q.owner != cmd_r.task_id) begin
          dec_status = ST_CONTENDED;
        end else begin
          wr_en         = 1'b1;
          wr_data.held  = 1'b1;
          wr_data.owner = cmd_r.task_id;
        end
      end
      KIND_UNLOCK: begin
        if (!found_r) begin
          dec_status = ST_UNKNOWN;
        end else begin
          wr_en        = 1'b1;
          wr_data.held = 1'b0;
        end
      end
      default: dec_status = ST_DONE;
    endcase
    if (!(state_r == BK_DECIDE && out_free)) begin
      wr_en     = 1'b0;
      count_nxt = count_r;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      BK_READ: idx_nxt = idx_r;
      BK_CMP: begin
        found_nxt = hit;
        if (!hit && !last_idx) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      BK_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dec_status;
        end
      end
      default: idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (take_cmd) begin
      cmd_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-STATUS_W){1'b0}}, status_r};

endmodule
`default_nettype wire

[src/rlt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Resource lock table checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
module rlt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled status item changed.");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("Status padding not zero.");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Status item present after reset.");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("Configuration channel not ready.");

endmodule

bind resource_lock_table_core rlt_checker u_rlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Resource lock table testbench
// Drives register, lock, unlock and no-op requests with random idling and stalls,
// predicts each status item and compares it with the block's output.
// ---------------------------------------------------------------------------
import rlt_pkg::*;

class lock_table_scoreboard;
  int unsigned limit_reg;
  int unsigned count;
  logic [63:0] ids [256];
  bit held [256];
  logic [62:0] owners [256];
  status_t pending [$];
  int errors;

  function new();
    limit_reg = 256;
    count = 0;
    errors = 0;
    foreach (held[i]) held[i] = 0;
  endfunction

  function int unsigned max_entries();
    int unsigned lim;
    lim = (limit_reg == 0) ? 256 : limit_reg;
    return (lim > 256) ? 256 : lim;
  endfunction

  function void note_request(kind_t kind, logic [63:0] rid, logic [62:0] tsk);
    int slot;
    status_t st;
    slot = -1;
    st = ST_DONE;
    for (int i = 0; i < count; i++) begin
      if (ids[i] == rid) begin
        slot = i;
        break;
      end
    end
    case (kind)
      KIND_REGISTER: begin
        if (slot >= 0) held[slot] = 0;
        else if (count >= max_entries()) st = ST_FULL;
        else begin
          ids[count] = rid;
          held[count] = 0;
          owners[count] = '0;
          count++;
        end
      end
      KIND_LOCK: begin
        if (slot < 0) st = ST_UNKNOWN;
        else if (held[slot] && owners[slot] != tsk) st = ST_CONTENDED;
        else begin
          held[slot] = 1;
          owners[slot] = tsk;
        end
      end
      KIND_UNLOCK: begin
        if (slot < 0) st = ST_UNKNOWN;
        else held[slot] = 0;
      end
      default: ;
    endcase
    pending.push_back(st);
  endfunction

  function void check_status(logic [7:0] data);
    status_t want;
    if (pending.size() == 0) begin
      $error("status item with none expected: %0d", data[1:0]);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (data[1:0] != want) begin
      $error("status: expected %0d, actual %0d", want, data[1:0]);
      errors++;
    end
    if (data[7:2] != '0) begin
      $error("padding: expected 0, actual %0d", data[7:2]);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [KIND_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  lock_table_scoreboard sb;
  int unsigned cycle_count;
  bit calm;
  bit hold_off;
  logic [63:0] pool [$];

  resource_lock_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 5000000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  initial begin
    out_tready = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 0;
      else out_tready <= calm || ($urandom_range(99) >= 37);
    end
  end

  task automatic send(kind_t kind, logic [63:0] rid, logic [62:0] tsk);
    if (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {1'b0, tsk, rid};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, rid, tsk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.limit_reg = value;
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] pick_id();
    if (pool.size() != 0 && $urandom_range(9) < 8)
      return pool[$urandom_range(pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n, int id_span);
    logic [63:0] rid;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      rid = pick_id();
      if (r < 30) begin
        if ($urandom_range(1)) rid = {$urandom, $urandom};
        if (pool.size() < id_span) pool.push_back(rid);
        send(KIND_REGISTER, rid, 63'({$urandom, $urandom}));
      end else if (r < 65) begin
        send(KIND_LOCK, rid, 63'($urandom_range(3)) | ($urandom_range(1) ?
             63'({$urandom, $urandom}) : 63'd0));
      end else if (r < 95) begin
        send(KIND_UNLOCK, rid, 63'({$urandom, $urandom}));
      end else begin
        send(KIND_NOP, rid, 63'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    sb = new();
    calm = 0;
    hold_off = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = KIND_REGISTER;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(KIND_LOCK, 64'h0, 63'h0);
    send(KIND_UNLOCK, '1, 63'h0);
    send(KIND_REGISTER, 64'h0, 63'h0);
    send(KIND_REGISTER, '1, '1);
    send(KIND_REGISTER, 64'h0, 63'h0);
    send(KIND_LOCK, '1, '1);
    send(KIND_LOCK, '1, '1);
    send(KIND_LOCK, '1, 63'h1);
    send(KIND_UNLOCK, '1, 63'h5);
    send(KIND_UNLOCK, '1, 63'h5);
    send(KIND_LOCK, 64'h0, 63'h0);
    send(KIND_REGISTER, 64'h0, 63'h0);
    send(KIND_LOCK, 64'h0, 63'h7);
    send(KIND_NOP, 64'h0, '1);
    write_limit(9'd2);
    send(KIND_REGISTER, 64'h5555_AAAA_5555_AAAA, 63'h0);
    send(KIND_REGISTER, '1, 63'h0);
    send(KIND_LOCK, '1, '1);
    write_limit(9'd1);
    send(KIND_REGISTER, 64'h1234, 63'h0);
    send(KIND_LOCK, 64'h0, 63'h3);
    write_limit(9'd0);
    pool.push_back(64'h0);
    pool.push_back('1);

    random_phase(200, 24);

    // Output stalled for a long stretch while requests keep coming.
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 24);
    join
    drain();

    calm = 1;
    random_phase(150, 40);
    calm = 0;
    write_limit(9'd300);
    random_phase(150, 60);
    write_limit(9'd5);
    random_phase(150, 60);
    write_limit(9'd256);
    pool.delete();
    random_phase(300, 300);

    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
